// File: rtl/tpsc_pkg.sv
// Shared types and constants for the two-point sensor calibration block.
`default_nettype none

package tpsc_pkg;

  localparam int unsigned DivSteps  = 31;  // quotient bits, one per divider cell
  localparam int unsigned RawW      = 16;
  localparam int unsigned DivW      = 16;  // magnitude of raw1 - raw0
  localparam int unsigned BaseW     = 15;  // point0 times scale
  localparam int unsigned ValW      = 24;
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned TempShift = 5;   // 256 / 8
  localparam int unsigned HumShift  = 7;   // 256 / 2

  typedef enum logic [CfgIdxW-1:0] {
    RegTempPoint0 = 4'd0,
    RegTempPoint1 = 4'd1,
    RegTempRaw0   = 4'd2,
    RegTempRaw1   = 4'd3,
    RegHumPoint0  = 4'd4,
    RegHumPoint1  = 4'd5,
    RegHumRaw0    = 4'd6,
    RegHumRaw1    = 4'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StSat   = 2'd1,
    StEqual = 2'd2
  } status_e;

  typedef struct packed {
    logic [9:0]  temp_point0_x8;
    logic [9:0]  temp_point1_x8;
    logic [15:0] temp_raw0;
    logic [15:0] temp_raw1;
    logic [7:0]  hum_point0_x2;
    logic [7:0]  hum_point1_x2;
    logic [15:0] hum_raw0;
    logic [15:0] hum_raw1;
  } cal_t;

  // Word that travels down the divider chain. nq holds the numerator bits not
  // yet consumed in its upper part and the quotient bits found so far below.
  typedef struct packed {
    logic             eq;
    logic             neg;
    logic [BaseW-1:0] base;
    logic [DivW-1:0]  div;
    logic [DivW-1:0]  rem;
    logic [DivSteps-1:0] nq;
  } div_word_t;

endpackage

`default_nettype wire

// File: rtl/tpsc_in_if.sv
// Input channel: mode and raw sample with a valid/ready handshake.
`default_nettype none

interface tpsc_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [15:0] raw_sample;

  modport source (output valid, mode, raw_sample, input ready);
  modport sink   (input valid, mode, raw_sample, output ready);
endinterface

`default_nettype wire

// File: rtl/tpsc_out_if.sv
// Output channel: calibrated value and status with a valid/ready handshake.
`default_nettype none

interface tpsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] calibrated_value;
  logic [1:0]         status;

  modport source (output valid, calibrated_value, status, input ready);
  modport sink   (input valid, calibrated_value, status, output ready);
endinterface

`default_nettype wire

// File: rtl/tpsc_front.sv
// Front end: point selection, differences, magnitudes and the numerator product.
`default_nettype none

module tpsc_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tpsc_pkg::cal_t      cal_i,
  input  wire logic                valid_i,
  output      logic                ready_o,
  input  wire logic                mode_i,
  input  wire logic [15:0]         raw_i,
  output      logic                valid_o,
  input  wire logic                ready_i,
  output      tpsc_pkg::div_word_t word_o
);

  logic [9:0]  p0, p1;
  logic [15:0] r0, r1;
  logic [16:0] diff, ddiv;
  logic [10:0] dp;
  logic [16:0] diff_mag, ddiv_mag;
  logic [10:0] dp_mag;
  logic [tpsc_pkg::BaseW-1:0] base;

  // First stage registers.
  logic        a_valid_q;
  logic        a_eq_q, a_neg_q, a_hum_q;
  logic [tpsc_pkg::BaseW-1:0] a_base_q;
  logic [tpsc_pkg::DivW-1:0]  a_div_q;
  logic [15:0] a_diff_q;
  logic [9:0]  a_dp_q;
  logic        a_ready;

  // Second stage.
  logic        b_valid_q;
  tpsc_pkg::div_word_t b_word_q;
  logic [25:0] prod;
  logic [tpsc_pkg::DivSteps-1:0] num;

  always_comb begin
    if (mode_i) begin
      p0 = {2'b00, cal_i.hum_point0_x2};
      p1 = {2'b00, cal_i.hum_point1_x2};
      r0 = cal_i.hum_raw0;
      r1 = cal_i.hum_raw1;
      base = {p0[7:0], 7'b0};
    end else begin
      p0 = cal_i.temp_point0_x8;
      p1 = cal_i.temp_point1_x8;
      r0 = cal_i.temp_raw0;
      r1 = cal_i.temp_raw1;
      base = {p0, 5'b0};
    end
    diff     = {raw_i[15], raw_i} - {r0[15], r0};
    ddiv     = {r1[15], r1} - {r0[15], r0};
    dp       = {1'b0, p1} - {1'b0, p0};
    diff_mag = diff[16] ? (17'd0 - diff) : diff;
    ddiv_mag = ddiv[16] ? (17'd0 - ddiv) : ddiv;
    dp_mag   = dp[10] ? (11'd0 - dp) : dp;
  end

  assign ready_o = !a_valid_q || a_ready;
  assign a_ready = !b_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (ready_o) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      a_eq_q   <= (ddiv == 17'd0);
      a_neg_q  <= diff[16] ^ dp[10] ^ ddiv[16];
      a_hum_q  <= mode_i;
      a_base_q <= base;
      a_div_q  <= ddiv_mag[15:0];
      a_diff_q <= diff_mag[15:0];
      a_dp_q   <= dp_mag[9:0];
    end
  end

  // Humidity differences fit in eight bits, so the product fits in 24 bits.
  assign prod = a_diff_q * a_dp_q;
  assign num  = a_hum_q ? {prod[23:0], 7'b0} : {prod, 5'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (a_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && a_valid_q) begin
      b_word_q.eq   <= a_eq_q;
      b_word_q.neg  <= a_neg_q;
      b_word_q.base <= a_base_q;
      b_word_q.div  <= a_div_q;
      b_word_q.rem  <= '0;
      b_word_q.nq   <= num;
    end
  end

  assign valid_o = b_valid_q;
  assign word_o  = b_word_q;

endmodule

`default_nettype wire

// File: rtl/tpsc_div_cell.sv
// One restoring-division cell: finds one quotient bit and registers the word.
`default_nettype none

module tpsc_div_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output      logic                ready_o,
  input  wire tpsc_pkg::div_word_t word_i,
  output      logic                valid_o,
  input  wire logic                ready_i,
  output      tpsc_pkg::div_word_t word_o
);

  logic                valid_q;
  tpsc_pkg::div_word_t word_q, word_d;
  logic [16:0]         rem_sh;
  logic [17:0]         trial;
  logic                ge;

  always_comb begin
    rem_sh = {word_i.rem, word_i.nq[tpsc_pkg::DivSteps-1]};
    trial  = {1'b0, rem_sh} - {2'b00, word_i.div};
    ge     = !trial[17];
    word_d = word_i;
    // The kept remainder is below the divisor, so it fits in sixteen bits.
    word_d.rem = ge ? trial[15:0] : rem_sh[15:0];
    word_d.nq  = {word_i.nq[tpsc_pkg::DivSteps-2:0], ge};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

// File: rtl/tpsc_back.sv
// Back end: quotient sign, base offset, 24-bit saturation and output register.
`default_nettype none

module tpsc_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output      logic                ready_o,
  input  wire tpsc_pkg::div_word_t word_i,
  tpsc_out_if.source               out_o
);

  logic                valid_q;
  logic [23:0]         val_q, val_d;
  tpsc_pkg::status_e   st_q, st_d;
  logic [32:0]         sq, sum;

  always_comb begin
    sq  = word_i.neg ? (33'd0 - {2'b00, word_i.nq}) : {2'b00, word_i.nq};
    sum = sq + {18'd0, word_i.base};
    if (word_i.eq) begin
      val_d = '0;
      st_d  = tpsc_pkg::StEqual;
    end else if (!sum[32] && (sum[31:23] != 9'd0)) begin
      val_d = 24'h7FFFFF;
      st_d  = tpsc_pkg::StSat;
    end else if (sum[32] && (sum[31:23] != 9'h1FF)) begin
      val_d = 24'h800000;
      st_d  = tpsc_pkg::StSat;
    end else begin
      val_d = sum[23:0];
      st_d  = tpsc_pkg::StOk;
    end
  end

  assign ready_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      val_q <= val_d;
      st_q  <= st_d;
    end
  end

  assign out_o.valid            = valid_q;
  assign out_o.calibrated_value = val_q;
  assign out_o.status           = st_q;

endmodule

`default_nettype wire

// File: rtl/two_point_sensor_calibration.sv
// Two-point linear calibration of raw temperature and humidity samples.
// A raw sample is turned into a value in 1/256 units by interpolating between the
// two calibration points of the chosen mode; the quotient truncates toward zero and
// results beyond 24 bits clamp with a saturated status. The block takes one word
// per clock while the output is not stalled: two front stages form the differences
// and the numerator product, a row of 31 divider cells finds one quotient bit each,
// and one output stage adds the base, saturates and registers the result.
// Every stage holds its word under backpressure and closes up empty slots, so a
// stalled output only blocks the input once the whole chain is full.
`default_nettype none

module two_point_sensor_calibration (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tpsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [tpsc_pkg::CfgDataW-1:0] cfg_data_i,
  tpsc_in_if.sink                            in_i,
  tpsc_out_if.source                         out_o
);

  tpsc_pkg::cal_t      cal_q;
  tpsc_pkg::div_word_t word [tpsc_pkg::DivSteps+1];
  logic                valid [tpsc_pkg::DivSteps+1];
  logic                ready [tpsc_pkg::DivSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_we_i) begin
      case (tpsc_pkg::reg_idx_e'(cfg_idx_i))
        tpsc_pkg::RegTempPoint0: cal_q.temp_point0_x8 <= cfg_data_i[9:0];
        tpsc_pkg::RegTempPoint1: cal_q.temp_point1_x8 <= cfg_data_i[9:0];
        tpsc_pkg::RegTempRaw0:   cal_q.temp_raw0      <= cfg_data_i;
        tpsc_pkg::RegTempRaw1:   cal_q.temp_raw1      <= cfg_data_i;
        tpsc_pkg::RegHumPoint0:  cal_q.hum_point0_x2  <= cfg_data_i[7:0];
        tpsc_pkg::RegHumPoint1:  cal_q.hum_point1_x2  <= cfg_data_i[7:0];
        tpsc_pkg::RegHumRaw0:    cal_q.hum_raw0       <= cfg_data_i;
        tpsc_pkg::RegHumRaw1:    cal_q.hum_raw1       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tpsc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cal_i   (cal_q),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .mode_i  (in_i.mode),
    .raw_i   (in_i.raw_sample),
    .valid_o (valid[0]),
    .ready_i (ready[0]),
    .word_o  (word[0])
  );

  for (genvar c = 0; c < tpsc_pkg::DivSteps; c++) begin : g_cell
    tpsc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[c]),
      .ready_o (ready[c]),
      .word_i  (word[c]),
      .valid_o (valid[c+1]),
      .ready_i (ready[c+1]),
      .word_o  (word[c+1])
    );
  end

  tpsc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid[tpsc_pkg::DivSteps]),
    .ready_o (ready[tpsc_pkg::DivSteps]),
    .word_i  (word[tpsc_pkg::DivSteps]),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// File: tb/tb_two_point_sensor_calibration.sv
// Self-checking testbench for the two-point sensor calibration block.
`default_nettype none

module tb_two_point_sensor_calibration;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRegs       = 8;
  localparam int NumPhases     = 12;
  localparam int ItemsPerPhase = 62;
  localparam int HoldPhase     = 3;
  localparam int LongHold      = 150;
  localparam int DrainCycles   = 40;

  localparam logic ModeTemp = 1'b0;
  localparam logic ModeHum  = 1'b1;

  localparam longint ValMax = (longint'(1) << (tpsc_pkg::ValW - 1)) - 1;
  localparam longint ValMin = -(longint'(1) << (tpsc_pkg::ValW - 1));

  typedef struct packed {
    logic signed [tpsc_pkg::ValW-1:0] value;
    tpsc_pkg::status_e                status;
  } cal_result_t;

  typedef struct packed {
    logic                          is_cfg;
    logic [tpsc_pkg::CfgIdxW-1:0]  idx;
    logic [tpsc_pkg::CfgDataW-1:0] data;
    logic                          mode;
    logic [tpsc_pkg::RawW-1:0]     raw;
    logic                          typed;
    cal_result_t                   golden;
  } stim_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [tpsc_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [tpsc_pkg::CfgDataW-1:0] cfg_data;

  tpsc_in_if  in_ch ();
  tpsc_out_if out_ch ();

  two_point_sensor_calibration u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  tpsc_pkg::cal_t cal_shadow;
  cal_result_t    pending_cal_q[$];
  stim_row_t      dir_rows[$];
  int             errors;
  int             checked;
  int             sat_seen;
  int             equal_seen;
  int             idle_pct;
  bit             hold_req;

  always #2 clk_i = ~clk_i;

  // Expected calibrated word for one sample under the current register set.
  function automatic cal_result_t calc_calibration(logic mode,
                                                   logic [tpsc_pkg::RawW-1:0] raw);
    longint      p0, p1, r0, r1, scale, span, val, raw_val;
    cal_result_t res;
    raw_val = longint'($signed(raw));
    if (mode == ModeHum) begin
      p0    = longint'(cal_shadow.hum_point0_x2);
      p1    = longint'(cal_shadow.hum_point1_x2);
      r0    = longint'($signed(cal_shadow.hum_raw0));
      r1    = longint'($signed(cal_shadow.hum_raw1));
      scale = longint'(1) << tpsc_pkg::HumShift;
    end else begin
      p0    = longint'(cal_shadow.temp_point0_x8);
      p1    = longint'(cal_shadow.temp_point1_x8);
      r0    = longint'($signed(cal_shadow.temp_raw0));
      r1    = longint'($signed(cal_shadow.temp_raw1));
      scale = longint'(1) << tpsc_pkg::TempShift;
    end
    span       = r1 - r0;
    res.status = tpsc_pkg::StOk;
    if (span == 0) begin
      val        = 0;
      res.status = tpsc_pkg::StEqual;
    end else begin
      // Integer division truncates toward zero, as the hardware quotient does.
      val = p0 * scale + ((raw_val - r0) * (p1 - p0) * scale) / span;
      if (val > ValMax) begin
        val        = ValMax;
        res.status = tpsc_pkg::StSat;
      end else if (val < ValMin) begin
        val        = ValMin;
        res.status = tpsc_pkg::StSat;
      end
    end
    res.value = val[tpsc_pkg::ValW-1:0];
    return res;
  endfunction

  function automatic void add_cfg(logic [tpsc_pkg::CfgIdxW-1:0] idx,
                                  logic [tpsc_pkg::CfgDataW-1:0] data);
    stim_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_item(logic mode, logic [tpsc_pkg::RawW-1:0] raw);
    stim_row_t row;
    row      = '0;
    row.mode = mode;
    row.raw  = raw;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_typed(logic mode, logic [tpsc_pkg::RawW-1:0] raw,
                                    logic [tpsc_pkg::ValW-1:0] value,
                                    tpsc_pkg::status_e status);
    stim_row_t row;
    row               = '0;
    row.mode          = mode;
    row.raw           = raw;
    row.typed         = 1'b1;
    row.golden.value  = value;
    row.golden.status = status;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [tpsc_pkg::CfgDataW-1:0] pick_point(int unsigned hi);
    logic [tpsc_pkg::CfgDataW-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = '0;
      1:       v = tpsc_pkg::CfgDataW'(hi);
      default: v = tpsc_pkg::CfgDataW'($urandom_range(0, hi));
    endcase
    // Junk above the field width has to be dropped by the register.
    if ($urandom_range(0, 1) == 1) begin
      v = v | (tpsc_pkg::CfgDataW'($urandom) & ~tpsc_pkg::CfgDataW'(hi));
    end
    return v;
  endfunction

  function automatic logic [tpsc_pkg::RawW-1:0] pick_raw();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return tpsc_pkg::RawW'($urandom_range(0, 64)) - tpsc_pkg::RawW'(32);
      default: return tpsc_pkg::RawW'($urandom);
    endcase
  endfunction

  // Drives one register write; the caller lowers the enable after a batch.
  task automatic cfg_put(logic [tpsc_pkg::CfgIdxW-1:0] idx,
                         logic [tpsc_pkg::CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      tpsc_pkg::RegTempPoint0: cal_shadow.temp_point0_x8 = data[9:0];
      tpsc_pkg::RegTempPoint1: cal_shadow.temp_point1_x8 = data[9:0];
      tpsc_pkg::RegTempRaw0:   cal_shadow.temp_raw0      = data;
      tpsc_pkg::RegTempRaw1:   cal_shadow.temp_raw1      = data;
      tpsc_pkg::RegHumPoint0:  cal_shadow.hum_point0_x2  = data[7:0];
      tpsc_pkg::RegHumPoint1:  cal_shadow.hum_point1_x2  = data[7:0];
      tpsc_pkg::RegHumRaw0:    cal_shadow.hum_raw0       = data;
      tpsc_pkg::RegHumRaw1:    cal_shadow.hum_raw1       = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_raw_pair(logic [tpsc_pkg::CfgIdxW-1:0] idx0,
                                logic [tpsc_pkg::CfgIdxW-1:0] idx1);
    logic [tpsc_pkg::RawW-1:0] r0, r1;
    r0 = pick_raw();
    case ($urandom_range(0, 7))
      0:       r1 = r0;
      // A span of a few counts drives most samples into saturation.
      1, 2:    r1 = r0 + tpsc_pkg::RawW'($urandom_range(0, 16)) - tpsc_pkg::RawW'(8);
      default: r1 = pick_raw();
    endcase
    cfg_put(idx0, r0);
    cfg_put(idx1, r1);
  endtask

  task automatic set_random_calibration();
    cfg_put(tpsc_pkg::RegTempPoint0, pick_point(1023));
    cfg_put(tpsc_pkg::RegTempPoint1, pick_point(1023));
    write_raw_pair(tpsc_pkg::RegTempRaw0, tpsc_pkg::RegTempRaw1);
    cfg_put(tpsc_pkg::RegHumPoint0, pick_point(255));
    cfg_put(tpsc_pkg::RegHumPoint1, pick_point(255));
    write_raw_pair(tpsc_pkg::RegHumRaw0, tpsc_pkg::RegHumRaw1);
    if ($urandom_range(0, 2) == 0) begin
      cfg_put(tpsc_pkg::CfgIdxW'(NumRegs + $urandom_range(0, 7)),
              tpsc_pkg::CfgDataW'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (pending_cal_q.size() != 0) @(posedge clk_i);
  endtask

  // Offers one word and returns at the edge where it is taken.
  task automatic push_sample(logic mode, logic [tpsc_pkg::RawW-1:0] raw, logic typed,
                             cal_result_t golden);
    int gap;
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      gap = $urandom_range(1, 15);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.raw_sample <= raw;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_cal_q.push_back(typed ? golden : calc_calibration(mode, raw));
  endtask

  initial begin
    #2000000;
    $display("** two_point_sensor_calibration: FAILED **");
    $finish;
  end

  // Output side: random stalls, one long hold on request, and the checker.
  initial begin
    int          stall_left;
    cal_result_t got, want;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got.value  = out_ch.calibrated_value;
        got.status = tpsc_pkg::status_e'(out_ch.status);
        if (pending_cal_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected word value=%0d status=%0d", $realtime,
                     got.value, got.status);
          end
        end else begin
          want = pending_cal_q.pop_front();
          checked++;
          if (want.status == tpsc_pkg::StSat) sat_seen++;
          if (want.status == tpsc_pkg::StEqual) equal_seen++;
          if (got.value !== want.value || got.status !== want.status) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch value exp=%0d got=%0d status exp=%0d got=%0d",
                       $realtime, want.value, got.value, want.status, got.status);
            end
          end
        end
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LongHold;
      end else if (stall_left == 0 && idle_pct != 0 &&
                   $urandom_range(1, 100) <= idle_pct) begin
        stall_left = $urandom_range(1, 15);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic                      m;
    logic [tpsc_pkg::RawW-1:0] r, r0, r1;
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = ModeTemp;
    in_ch.raw_sample = '0;
    out_ch.ready     = 1'b0;
    cal_shadow       = '0;
    errors           = 0;
    checked          = 0;
    sat_seen         = 0;
    equal_seen       = 0;
    idle_pct         = 15;
    hold_req         = 1'b0;

    // Registers come out of reset as zero, so both raw spans are empty.
    add_typed(ModeTemp, 16'h0000, 24'd0, tpsc_pkg::StEqual);
    add_typed(ModeHum,  16'h8000, 24'd0, tpsc_pkg::StEqual);
    // Full temperature range, with junk above the 10-bit point fields.
    add_cfg(tpsc_pkg::RegTempPoint0, 16'hFC00);
    add_cfg(tpsc_pkg::RegTempPoint1, 16'hFFFF);
    add_cfg(tpsc_pkg::RegTempRaw0,   16'h8000);
    add_cfg(tpsc_pkg::RegTempRaw1,   16'h7FFF);
    add_typed(ModeTemp, 16'h8000, 24'd0, tpsc_pkg::StOk);
    add_typed(ModeTemp, 16'h7FFF, 24'd32736, tpsc_pkg::StOk);
    add_item(ModeTemp, 16'h0000);
    add_item(ModeTemp, 16'h1234);
    // Falling humidity line over the whole raw range.
    add_cfg(tpsc_pkg::RegHumPoint0, 16'hFFFF);
    add_cfg(tpsc_pkg::RegHumPoint1, 16'hFF00);
    add_cfg(tpsc_pkg::RegHumRaw0,   16'h7FFF);
    add_cfg(tpsc_pkg::RegHumRaw1,   16'h8000);
    add_typed(ModeHum, 16'h7FFF, 24'd32640, tpsc_pkg::StOk);
    add_typed(ModeHum, 16'h8000, 24'd0, tpsc_pkg::StOk);
    add_item(ModeHum, 16'hFFFF);
    // A one-count temperature span saturates both ways.
    add_cfg(tpsc_pkg::RegTempRaw0, 16'h0000);
    add_cfg(tpsc_pkg::RegTempRaw1, 16'h0001);
    add_typed(ModeTemp, 16'h7FFF, 24'h7FFFFF, tpsc_pkg::StSat);
    add_typed(ModeTemp, 16'h8000, 24'h800000, tpsc_pkg::StSat);
    add_typed(ModeTemp, 16'h0001, 24'd32736, tpsc_pkg::StOk);
    add_typed(ModeTemp, 16'h0000, 24'd0, tpsc_pkg::StOk);
    // Writes past the last register must leave the set untouched.
    add_cfg(tpsc_pkg::CfgIdxW'(NumRegs + 1), 16'h0005);
    add_cfg(tpsc_pkg::CfgIdxW'(NumRegs + 7), 16'hFFFF);
    add_typed(ModeTemp, 16'h0001, 24'd32736, tpsc_pkg::StOk);
    // Equal humidity raw points, then a one-count span on a falling line.
    add_cfg(tpsc_pkg::RegHumRaw0, 16'h1234);
    add_cfg(tpsc_pkg::RegHumRaw1, 16'h1234);
    add_typed(ModeHum, 16'h1234, 24'd0, tpsc_pkg::StEqual);
    add_typed(ModeHum, 16'h0000, 24'd0, tpsc_pkg::StEqual);
    add_cfg(tpsc_pkg::RegHumRaw1, 16'h1235);
    add_typed(ModeHum, 16'h8000, 24'h7FFFFF, tpsc_pkg::StSat);
    add_typed(ModeHum, 16'h7FFF, 24'h800000, tpsc_pkg::StSat);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        in_ch.valid <= 1'b0;
        wait_drained();
        cfg_put(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        cfg_we <= 1'b0;
        push_sample(dir_rows[i].mode, dir_rows[i].raw, dir_rows[i].typed,
                    dir_rows[i].golden);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      in_ch.valid <= 1'b0;
      wait_drained();
      set_random_calibration();
      cfg_we <= 1'b0;
      if (p >= NumPhases - 2 || p == HoldPhase || p % 4 == 1) begin
        idle_pct = 0;
      end else if (p % 4 == 2) begin
        idle_pct = 40;
      end else begin
        idle_pct = 15;
      end
      // The output holds off long enough for the pipeline to fill and push back.
      if (p == HoldPhase) hold_req = 1'b1;
      for (int k = 0; k < ItemsPerPhase; k++) begin
        m  = ($urandom_range(0, 1) == 1) ? ModeHum : ModeTemp;
        r0 = (m == ModeHum) ? cal_shadow.hum_raw0 : cal_shadow.temp_raw0;
        r1 = (m == ModeHum) ? cal_shadow.hum_raw1 : cal_shadow.temp_raw1;
        case ($urandom_range(0, 9))
          0:       r = 16'h8000;
          1:       r = 16'h7FFF;
          2:       r = r0 + tpsc_pkg::RawW'($urandom_range(0, 6)) - tpsc_pkg::RawW'(3);
          3:       r = r1 + tpsc_pkg::RawW'($urandom_range(0, 6)) - tpsc_pkg::RawW'(3);
          default: r = tpsc_pkg::RawW'($urandom);
        endcase
        push_sample(m, r, 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    errors += pending_cal_q.size();

    $display("Checked %0d words over %0d random register sets plus the directed set.",
             checked, NumPhases);
    $display("%0d saturated, %0d with equal raw points, one %0d-cycle output hold.",
             sat_seen, equal_seen, LongHold);
    if (errors == 0) begin
      $display("** two_point_sensor_calibration: PASSED **");
    end else begin
      $display("** two_point_sensor_calibration: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/tpsc_pkg.sv
rtl/tpsc_in_if.sv
rtl/tpsc_out_if.sv
rtl/tpsc_front.sv
rtl/tpsc_div_cell.sv
rtl/tpsc_back.sv
rtl/two_point_sensor_calibration.sv
tb/tb_two_point_sensor_calibration.sv
